// File: design/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg
// shared types and constants for the dns name label encoder
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int          MAX_LABEL_DEF = 62;
    localparam logic [7:0]  DOT_CHAR      = 8'h2E;
    localparam logic [7:0]  TERM_BYTE     = 8'h00;

    typedef struct packed {
        logic [7:0] character;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       overflow;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_TERM
    } enc_state_t;

endpackage

// File: design/dnle_store.sv
// ----------------------------------------------------------------------------
// dnle_store
// label byte buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module dnle_store
    import dnle_pkg::*;
#(
    parameter int DEPTH = MAX_LABEL_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/dns_name_label_encoder_unit.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder_unit
// dotted name to dns wire labels, one character beat in, one wire byte out
// ----------------------------------------------------------------------------
// A character beat that neither is a dot nor is marked last gives no output;
// it is written into the label buffer at the current count, or dropped
// (setting the label's overflow flag) once MAX_LABEL bytes are held. A dot
// or a last beat closes the label: the unit then sends the length byte, the
// n buffered bytes and, for a last beat, the zero terminator, one output
// beat per cycle while out_ready stays high. Input is not taken while a
// label is being sent, since the single read port of the label buffer is
// walked one entry per cycle; the output register lets the final beat wait
// while the next character is accepted. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit
    import dnle_pkg::*;
#(
    parameter int MAX_LABEL = MAX_LABEL_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int CW = $clog2(MAX_LABEL + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LABEL);

    enc_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic           last_reg, last_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic           out_valid_reg, out_valid_next;
    out_beat_t      out_data_reg, out_data_next;

    logic           accept;
    logic           slot_free;
    logic           is_dot;
    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [7:0]     mem_rdata;
    logic           idx_final;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign is_dot    = (in_data.character == DOT_CHAR);
    assign mem_we    = accept && !is_dot && (count_reg < MAX_CNT);
    assign idx_final = ((CW'(idx_reg) + CW'(1)) == count_reg);

    dnle_store #(
        .DEPTH (MAX_LABEL),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_data.character),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (!is_dot)
                    begin
                        if (count_reg < MAX_CNT)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    last_next = in_data.is_last;
                    if (is_dot || in_data.is_last)
                    begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_byte = 8'(count_reg);
                    out_data_next.overflow = ovf_reg;
                    out_data_next.run_last = (count_reg == '0) && !last_reg;
                    idx_next               = '0;
                    if (count_reg == '0)
                    begin
                        ovf_next   = 1'b0;
                        state_next = last_reg ? ST_TERM : ST_IDLE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_byte = mem_rdata;
                    out_data_next.overflow = ovf_reg;
                    out_data_next.run_last = idx_final && !last_reg;
                    if (idx_final)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = last_reg ? ST_TERM : ST_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + AW'(1);
                        idx_next  = idx_reg + AW'(1);
                    end
                end
            end
            ST_TERM:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_byte = TERM_BYTE;
                    out_data_next.overflow = 1'b0;
                    out_data_next.run_last = 1'b1;
                    count_next             = '0;
                    ovf_next               = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // buffered count never passes the label limit
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= MAX_CNT)
        else $error("label count above limit");

    // a stored character advances the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && !in_data.is_last |=> count_reg == $past(count_reg) + CW'(1))
        else $error("count did not advance on buffered character");

    // a beat that is not the final one of its item leaves the encoder busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.run_last |-> state_reg != ST_IDLE)
        else $error("encoder idle with beats still owed");

    // the terminator never carries the overflow flag
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TERM && slot_free |=> !out_data_reg.overflow)
        else $error("terminator flagged as overflow");
`endif

endmodule
